### hw/rtl/xmrt_pkg.sv
// package: item types, codes and constants for the xor-metric routing table
`default_nettype none
package xmrt_pkg;

    localparam int ID_BITS_DEF      = 64;
    localparam int BUCKET_SLOTS_DEF = 16;
    localparam int ADDR_BITS_DEF    = 48;
    localparam int SEARCH_LIMIT     = 16;

    localparam logic [31:0] LINGER_RESET = 32'd3600000000;

    localparam logic [1:0] REQ_ALIVE   = 2'd0;
    localparam logic [1:0] REQ_TIMEOUT = 2'd1;
    localparam logic [1:0] REQ_SEARCH  = 2'd2;

    localparam logic [2:0] ST_REFRESHED = 3'd0;
    localparam logic [2:0] ST_DEAD      = 3'd1;
    localparam logic [2:0] ST_IGNORED   = 3'd2;
    localparam logic [2:0] ST_REPLACED  = 3'd3;
    localparam logic [2:0] ST_DROPPED   = 3'd4;
    localparam logic [2:0] ST_INSERTED  = 3'd5;
    localparam logic [2:0] ST_FOUND     = 3'd6;
    localparam logic [2:0] ST_EMPTY     = 3'd7;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] node_id;
        logic [47:0] node_addr;
        logic [47:0] now_time;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] found_id;
        logic [47:0] found_addr;
        logic [10:0] peer_count;
        logic        last;
    } t_out_item;

endpackage
`default_nettype wire

### hw/rtl/xor_metric_routing_table.sv
// top level: xor-metric routing table with an entry store (one write and one read port) and a sequencer
//
// Input channel i_in_valid / i_in_item / o_in_stall carries one request per item:
// update alive, update timed out, or search closest. The block stalls its input
// while a request is being worked on. Results leave on o_out_valid / o_out_item /
// i_out_stall through an output register; an update gives one item, a search gives
// up to 16 found items or one empty item, the final one flagged by last.
// The entry store has registered read data, so each slot scan, shift, split move or
// search check reads an entry and then acts on it. The bucket find walks the buckets
// in turn; a split moves every slot of the full last bucket into it or the next one.
// A search walks buckets, scans each matching bucket entry by entry, then emits
// one result per cycle while the receiver does not stall. An update's length grows
// with the bucket fill, the bucket find and each split; one request at a time.
// A stalled receiver holds the result register and the sequencer waits there.
// Reset empties the table (bucket fill valid bits and peer count cleared, bucket total
// set to one), sets own_id to zero and linger_time to 3600 s. Configuration goes through the
// APB port at byte addresses 0 (own_id) and 8 (linger_time), 64-bit data.
`default_nettype none
module xor_metric_routing_table #(
    parameter int ID_BITS      = xmrt_pkg::ID_BITS_DEF,
    parameter int BUCKET_SLOTS = xmrt_pkg::BUCKET_SLOTS_DEF,
    parameter int ADDR_BITS    = xmrt_pkg::ADDR_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  xmrt_pkg::t_in_item  i_in_item,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output xmrt_pkg::t_out_item o_out_item,
    input  wire                 i_out_stall,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [3:0]          paddr,
    input  wire  [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);

    localparam int AW        = (ADDR_BITS < 48) ? ADDR_BITS : 48;
    localparam int SLOTS_ALL = ID_BITS * BUCKET_SLOTS;
    localparam int MW        = $clog2(SLOTS_ALL);
    localparam int BW        = $clog2(ID_BITS);
    localparam int TW        = $clog2(ID_BITS + 1);
    localparam int FW        = $clog2(BUCKET_SLOTS + 1);
    localparam int PW        = $clog2(SLOTS_ALL + 1);
    localparam int CW        = $clog2(xmrt_pkg::SEARCH_LIMIT + 1);
    localparam int IW        = $clog2(xmrt_pkg::SEARCH_LIMIT);

    typedef struct packed {
        logic               alive;
        logic [47:0]        tstamp;
        logic [AW-1:0]      addr;
        logic [ID_BITS-1:0] id;
    } t_entry;

    typedef enum logic [18:0] {
        S_IDLE      = 19'h00001,
        S_FIND      = 19'h00002,
        S_UPD_FILL  = 19'h00004,
        S_SCAN      = 19'h00008,
        S_SCAN_CHK  = 19'h00010,
        S_UPD_END   = 19'h00020,
        S_SHIFT     = 19'h00040,
        S_SHIFT_WR  = 19'h00080,
        S_SPLIT_CHK = 19'h00100,
        S_SPLIT_RD  = 19'h00200,
        S_SPLIT_WR  = 19'h00400,
        S_SPLIT_FIN = 19'h00800,
        S_RESP      = 19'h01000,
        S_SR_STEP   = 19'h02000,
        S_SR_FILL   = 19'h04000,
        S_SR_SCAN   = 19'h08000,
        S_SR_CHK    = 19'h10000,
        S_SR_ADV    = 19'h20000,
        S_EMIT      = 19'h40000
    } t_state;

    function automatic logic [MW-1:0] slot_addr(input logic [BW-1:0] bkt,
                                                input logic [FW-1:0] slot);
        return MW'(bkt) * MW'(BUCKET_SLOTS) + MW'(slot);
    endfunction

    t_state              r_state, n_state;
    logic [1:0]          r_req, n_req;
    logic [ID_BITS-1:0]  r_id, n_id;
    logic [AW-1:0]       r_addr, n_addr;
    logic [47:0]         r_now, n_now;
    logic [ID_BITS-1:0]  r_metric, n_metric;
    logic [BW-1:0]       r_bkt, n_bkt;
    logic [FW-1:0]       r_slot, n_slot;
    logic [FW-1:0]       r_n, n_n;
    logic [FW-1:0]       r_k, n_k;
    logic [FW-1:0]       r_m, n_m;
    logic [FW-1:0]       r_rep, n_rep;
    logic                r_has_rep, n_has_rep;
    logic [TW-1:0]       r_total, n_total;
    logic [PW-1:0]       r_peer, n_peer;
    logic [2:0]          r_status, n_status;
    logic                r_fwd, n_fwd;
    logic                r_full, n_full;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [IW-1:0]       r_emit, n_emit;

    logic [63:0]         r_own_id;
    logic [31:0]         r_linger;

    logic                r_out_valid;
    xmrt_pkg::t_out_item r_out;

    t_entry              r_ent_mem [SLOTS_ALL];
    t_entry              r_ent_rd;
    logic [FW-1:0]       r_fill_mem [ID_BITS];
    logic [ID_BITS-1:0]  r_fill_vld;
    logic [FW-1:0]       r_fill_rd;
    logic [ID_BITS-1:0]  r_buf_id [xmrt_pkg::SEARCH_LIMIT];
    logic [AW-1:0]       r_buf_addr [xmrt_pkg::SEARCH_LIMIT];

    logic                in_acc;
    logic                out_free;
    logic                out_load;
    xmrt_pkg::t_out_item out_next;
    logic                ent_we;
    logic [MW-1:0]       ent_waddr;
    logic [MW-1:0]       ent_raddr;
    t_entry              ent_wdata;
    t_entry              new_ent;
    logic                fill_we;
    logic [BW-1:0]       fill_waddr;
    logic [FW-1:0]       fill_wdata;
    logic                buf_we;
    logic [BW-1:0]       bit_idx;
    logic                metric_bit;
    logic [ID_BITS-1:0]  split_xor;
    logic [47:0]         age;
    logic                keep;
    logic                last_bkt;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign pready = 1'b1;
    always_comb begin
        if (!psel) begin
            prdata = '0;
        end else if (paddr[3]) begin
            prdata = {32'd0, r_linger};
        end else begin
            prdata = r_own_id;
        end
    end

    assign bit_idx    = BW'(ID_BITS - 1) - r_bkt;
    assign metric_bit = r_metric[bit_idx];
    assign split_xor  = r_ent_rd.id ^ r_own_id[ID_BITS-1:0];
    assign age        = r_now - r_ent_rd.tstamp;
    assign keep       = r_full || r_ent_rd.alive || (r_now < r_ent_rd.tstamp)
                        || (age < {16'd0, r_linger});
    assign last_bkt   = (TW'(r_bkt) + TW'(1)) == r_total;
    assign new_ent    = '{alive: 1'b1, tstamp: r_now, addr: r_addr, id: r_id};

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_id      = r_id;
        n_addr    = r_addr;
        n_now     = r_now;
        n_metric  = r_metric;
        n_bkt     = r_bkt;
        n_slot    = r_slot;
        n_n       = r_n;
        n_k       = r_k;
        n_m       = r_m;
        n_rep     = r_rep;
        n_has_rep = r_has_rep;
        n_total   = r_total;
        n_peer    = r_peer;
        n_status  = r_status;
        n_fwd     = r_fwd;
        n_full    = r_full;
        n_cnt     = r_cnt;
        n_emit    = r_emit;
        ent_we     = 1'b0;
        ent_waddr  = slot_addr(r_bkt, r_slot);
        ent_raddr  = slot_addr(r_bkt, r_slot);
        ent_wdata  = r_ent_rd;
        fill_we    = 1'b0;
        fill_waddr = r_bkt;
        fill_wdata = r_n;
        buf_we     = 1'b0;
        out_load   = 1'b0;
        out_next   = '0;
        out_next.peer_count = 11'(r_peer);
        out_next.last       = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_req    = i_in_item.req_type;
                    n_id     = i_in_item.node_id[ID_BITS-1:0];
                    n_addr   = i_in_item.node_addr[AW-1:0];
                    n_now    = i_in_item.now_time;
                    n_metric = r_own_id[ID_BITS-1:0] ^ i_in_item.node_id[ID_BITS-1:0];
                    n_bkt    = '0;
                    case (i_in_item.req_type)
                        xmrt_pkg::REQ_ALIVE, xmrt_pkg::REQ_TIMEOUT: begin
                            n_state = S_FIND;
                        end
                        xmrt_pkg::REQ_SEARCH: begin
                            n_fwd   = 1'b1;
                            n_full  = 1'b0;
                            n_cnt   = '0;
                            n_state = S_SR_STEP;
                        end
                        default: begin
                            n_status = xmrt_pkg::ST_IGNORED;
                            n_state  = S_RESP;
                        end
                    endcase
                end
            end
            S_FIND: begin
                if (last_bkt || metric_bit) begin
                    n_state = S_UPD_FILL;
                end else begin
                    n_bkt = r_bkt + BW'(1);
                end
            end
            S_UPD_FILL: begin
                n_n       = r_fill_rd;
                n_slot    = '0;
                n_has_rep = 1'b0;
                n_state   = S_SCAN;
            end
            S_SCAN: begin
                n_state = (r_slot == r_n) ? S_UPD_END : S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                n_slot  = r_slot + FW'(1);
                n_state = S_SCAN;
                if (r_ent_rd.id == r_id) begin
                    n_state = S_RESP;
                    if (r_req == xmrt_pkg::REQ_ALIVE) begin
                        ent_we    = 1'b1;
                        ent_wdata = new_ent;
                        n_status  = xmrt_pkg::ST_REFRESHED;
                    end else if (r_ent_rd.addr == r_addr) begin
                        ent_we          = 1'b1;
                        ent_wdata.alive = 1'b0;
                        n_status        = xmrt_pkg::ST_DEAD;
                    end else begin
                        n_status = xmrt_pkg::ST_IGNORED;
                    end
                end else if (!r_ent_rd.alive) begin
                    n_has_rep = 1'b1;
                    n_rep     = r_slot;
                end
            end
            S_UPD_END: begin
                if (r_req != xmrt_pkg::REQ_ALIVE) begin
                    n_status = xmrt_pkg::ST_IGNORED;
                    n_state  = S_RESP;
                end else if (r_n == FW'(BUCKET_SLOTS)) begin
                    n_state = S_RESP;
                    if (r_has_rep) begin
                        ent_we    = 1'b1;
                        ent_waddr = slot_addr(r_bkt, r_rep);
                        ent_wdata = new_ent;
                        n_status  = xmrt_pkg::ST_REPLACED;
                    end else begin
                        n_status = xmrt_pkg::ST_DROPPED;
                    end
                end else begin
                    n_slot  = r_n;
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (r_slot == '0) begin
                    ent_we     = 1'b1;
                    ent_wdata  = new_ent;
                    fill_we    = 1'b1;
                    fill_wdata = r_n + FW'(1);
                    n_n        = r_n + FW'(1);
                    n_peer     = r_peer + PW'(1);
                    n_state    = S_SPLIT_CHK;
                end else begin
                    ent_raddr = slot_addr(r_bkt, r_slot - FW'(1));
                    n_state   = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                ent_we  = 1'b1;
                n_slot  = r_slot - FW'(1);
                n_state = S_SHIFT;
            end
            S_SPLIT_CHK: begin
                if (r_n == FW'(BUCKET_SLOTS) && last_bkt && r_total < TW'(ID_BITS)) begin
                    n_slot  = '0;
                    n_k     = '0;
                    n_m     = '0;
                    n_state = S_SPLIT_RD;
                end else begin
                    n_status = xmrt_pkg::ST_INSERTED;
                    n_state  = S_RESP;
                end
            end
            S_SPLIT_RD: begin
                if (r_slot == FW'(BUCKET_SLOTS)) begin
                    fill_we    = 1'b1;
                    fill_wdata = r_k;
                    n_state    = S_SPLIT_FIN;
                end else begin
                    n_state = S_SPLIT_WR;
                end
            end
            S_SPLIT_WR: begin
                ent_we = 1'b1;
                if (!split_xor[bit_idx]) begin
                    ent_waddr = slot_addr(r_bkt + BW'(1), r_m);
                    n_m       = r_m + FW'(1);
                end else begin
                    ent_waddr = slot_addr(r_bkt, r_k);
                    n_k       = r_k + FW'(1);
                end
                n_slot  = r_slot + FW'(1);
                n_state = S_SPLIT_RD;
            end
            S_SPLIT_FIN: begin
                fill_we    = 1'b1;
                fill_waddr = r_bkt + BW'(1);
                fill_wdata = r_m;
                n_total    = r_total + TW'(1);
                n_bkt      = r_bkt + BW'(1);
                n_n        = r_m;
                n_state    = S_SPLIT_CHK;
            end
            S_RESP: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    out_next.status = r_status;
                    n_state         = S_IDLE;
                end
            end
            S_SR_STEP: begin
                n_state = (metric_bit == r_fwd) ? S_SR_FILL : S_SR_ADV;
            end
            S_SR_FILL: begin
                n_n     = r_fill_rd;
                n_slot  = '0;
                n_k     = '0;
                n_state = S_SR_SCAN;
            end
            S_SR_SCAN: begin
                if (r_slot == r_n) begin
                    fill_we    = 1'b1;
                    fill_wdata = r_k;
                    n_state    = S_SR_ADV;
                end else begin
                    n_state = S_SR_CHK;
                end
            end
            S_SR_CHK: begin
                if (keep) begin
                    if (!r_full) begin
                        buf_we = 1'b1;
                        n_cnt  = r_cnt + CW'(1);
                        if (r_cnt == CW'(xmrt_pkg::SEARCH_LIMIT - 1)) begin
                            n_full = 1'b1;
                        end
                    end
                    ent_we    = 1'b1;
                    ent_waddr = slot_addr(r_bkt, r_k);
                    n_k       = r_k + FW'(1);
                end else begin
                    n_peer = r_peer - PW'(1);
                end
                n_slot  = r_slot + FW'(1);
                n_state = S_SR_SCAN;
            end
            S_SR_ADV: begin
                n_state = S_SR_STEP;
                if (r_full) begin
                    n_emit  = '0;
                    n_state = S_EMIT;
                end else if (r_fwd) begin
                    if (last_bkt) begin
                        n_fwd = 1'b0;
                    end else begin
                        n_bkt = r_bkt + BW'(1);
                    end
                end else if (r_bkt == '0) begin
                    n_emit  = '0;
                    n_state = S_EMIT;
                end else begin
                    n_bkt = r_bkt - BW'(1);
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_cnt == '0) begin
                        out_next.status = xmrt_pkg::ST_EMPTY;
                        n_state         = S_IDLE;
                    end else begin
                        out_next.status     = xmrt_pkg::ST_FOUND;
                        out_next.found_id   = 64'(r_buf_id[r_emit]);
                        out_next.found_addr = 48'(r_buf_addr[r_emit]);
                        out_next.last       = (CW'(r_emit) + CW'(1)) == r_cnt;
                        n_emit              = r_emit + IW'(1);
                        if (out_next.last) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= TW'(1);
            r_peer      <= '0;
            r_out_valid <= 1'b0;
            r_fill_vld  <= '0;
            r_own_id    <= '0;
            r_linger    <= xmrt_pkg::LINGER_RESET;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_peer  <= n_peer;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (fill_we) begin
                r_fill_vld[fill_waddr] <= 1'b1;
            end
            if (psel && penable && pwrite) begin
                if (paddr[3]) begin
                    r_linger <= pwdata[31:0];
                end else begin
                    r_own_id <= pwdata;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_id      <= n_id;
        r_addr    <= n_addr;
        r_now     <= n_now;
        r_metric  <= n_metric;
        r_bkt     <= n_bkt;
        r_slot    <= n_slot;
        r_n       <= n_n;
        r_k       <= n_k;
        r_m       <= n_m;
        r_rep     <= n_rep;
        r_has_rep <= n_has_rep;
        r_status  <= n_status;
        r_fwd     <= n_fwd;
        r_full    <= n_full;
        r_cnt     <= n_cnt;
        r_emit    <= n_emit;
        if (out_load) begin
            r_out <= out_next;
        end
        if (buf_we) begin
            r_buf_id[r_cnt[IW-1:0]]   <= r_ent_rd.id;
            r_buf_addr[r_cnt[IW-1:0]] <= r_ent_rd.addr;
        end
    end

    // entry store, one write and one read port
    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            r_ent_mem[ent_waddr] <= ent_wdata;
        end
        r_ent_rd <= r_ent_mem[ent_raddr];
    end

    // bucket fill store, unwritten buckets read as empty
    always_ff @(posedge i_clk) begin
        if (fill_we) begin
            r_fill_mem[fill_waddr] <= fill_wdata;
        end
        r_fill_rd <= r_fill_vld[r_bkt] ? r_fill_mem[r_bkt] : '0;
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

    a_peer_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peer <= PW'(SLOTS_ALL))
        else $error("peer count beyond table size");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_total != '0) && (r_total <= TW'(ID_BITS)))
        else $error("bucket total out of range");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_CHK || r_state == S_SR_CHK) |-> (r_slot < r_n))
        else $error("slot check beyond bucket fill");

    a_result_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_cnt <= CW'(xmrt_pkg::SEARCH_LIMIT)))
        else $error("search collected too many items");

endmodule
`default_nettype wire

### tb/tb_xor_metric_routing_table.sv
// testbench: directed table and random requests against a behavioural routing table model
`timescale 1ns / 1ps
module tb_xor_metric_routing_table;

    localparam int  SLOTS      = xmrt_pkg::BUCKET_SLOTS_DEF;
    localparam int  NBKT       = xmrt_pkg::ID_BITS_DEF;
    localparam int  CYCLE_CAP  = 1000000;
    localparam logic [3:0] ADDR_OWN_ID = 4'd0;
    localparam logic [3:0] ADDR_LINGER = 4'd8;
    localparam logic [1:0] REQ_UNUSED  = 2'd3;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    xmrt_pkg::t_in_item  i_in_item;
    logic                o_in_stall;
    logic                o_out_valid;
    xmrt_pkg::t_out_item o_out_item;
    logic                i_out_stall;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [3:0]          paddr;
    logic [63:0]         pwdata;
    logic [63:0]         prdata;
    logic                pready;

    xor_metric_routing_table i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_item(i_in_item), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .o_out_item(o_out_item), .i_out_stall(i_out_stall),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // shadow routing table
    logic [63:0] tbl_id    [SLOTS*NBKT];
    logic [47:0] tbl_addr  [SLOTS*NBKT];
    logic [47:0] tbl_time  [SLOTS*NBKT];
    bit          tbl_alive [SLOTS*NBKT];
    int          tbl_fill  [NBKT];
    int          tbl_buckets;
    logic [10:0] tbl_peers;
    logic [63:0] cfg_own_id;
    logic [31:0] cfg_linger;

    xmrt_pkg::t_out_item results_due[$];
    int          n_items, n_results, n_errors, n_found, cycles, burst_left;

    function automatic void slot_copy(int d, int s);
        tbl_id[d] = tbl_id[s];
        tbl_addr[d] = tbl_addr[s];
        tbl_time[d] = tbl_time[s];
        tbl_alive[d] = tbl_alive[s];
    endfunction

    function automatic void slot_write(int s, logic [63:0] id, logic [47:0] a, logic [47:0] t);
        tbl_id[s] = id;
        tbl_addr[s] = a;
        tbl_time[s] = t;
        tbl_alive[s] = 1'b1;
    endfunction

    function automatic void push_result(logic [2:0] st, logic [63:0] id, logic [47:0] a,
                                        bit lst);
        xmrt_pkg::t_out_item r;
        r.status = st;
        r.found_id = id;
        r.found_addr = a;
        r.peer_count = tbl_peers;
        r.last = lst;
        results_due.push_back(r);
    endfunction

    function automatic logic [2:0] table_update(logic [63:0] id, logic [47:0] a,
                                                logic [47:0] now, bit alive);
        logic [63:0] metric;
        int b, base, n, s, i, rep, nb, k, m;
        bit has_rep;
        metric = cfg_own_id ^ id;
        b = 0;
        has_rep = 0;
        rep = 0;
        while (b + 1 < tbl_buckets && !metric[63-b]) b++;
        base = b * SLOTS;
        n = tbl_fill[b];
        for (s = 0; s < n; s++) begin
            i = base + s;
            if (tbl_id[i] == id) begin
                if (alive) begin
                    slot_write(i, id, a, now);
                    return xmrt_pkg::ST_REFRESHED;
                end
                if (tbl_addr[i] == a) begin
                    tbl_alive[i] = 1'b0;
                    return xmrt_pkg::ST_DEAD;
                end
                return xmrt_pkg::ST_IGNORED;
            end
            if (!tbl_alive[i]) begin
                has_rep = 1;
                rep = i;
            end
        end
        if (!alive) return xmrt_pkg::ST_IGNORED;
        if (n >= SLOTS) begin
            if (has_rep) begin
                slot_write(rep, id, a, now);
                return xmrt_pkg::ST_REPLACED;
            end
            return xmrt_pkg::ST_DROPPED;
        end
        for (s = n; s > 0; s--) slot_copy(base + s, base + s - 1);
        slot_write(base, id, a, now);
        tbl_fill[b] = n + 1;
        tbl_peers++;
        while (tbl_fill[b] == SLOTS && b + 1 == tbl_buckets && tbl_buckets < NBKT) begin
            nb = (b + 1) * SLOTS;
            base = b * SLOTS;
            k = 0;
            m = 0;
            for (s = 0; s < SLOTS; s++) begin
                i = base + s;
                metric = tbl_id[i] ^ cfg_own_id;
                if (!metric[63-b]) begin
                    slot_copy(nb + m, i);
                    m++;
                end else begin
                    slot_copy(base + k, i);
                    k++;
                end
            end
            tbl_fill[b] = k;
            tbl_fill[b+1] = m;
            tbl_buckets++;
            b++;
        end
        return xmrt_pkg::ST_INSERTED;
    endfunction

    function automatic void table_search(logic [63:0] target, logic [47:0] now);
        logic [63:0] metric;
        logic [63:0] ids[$];
        logic [47:0] addrs[$];
        int b, base, n, s, i, w;
        bit fwd, full, keep;
        metric = cfg_own_id ^ target;
        b = 0;
        fwd = 1;
        full = 0;
        while (b >= 0 && !full) begin
            if (metric[63-b] == fwd) begin
                base = b * SLOTS;
                n = tbl_fill[b];
                w = 0;
                for (s = 0; s < n; s++) begin
                    i = base + s;
                    keep = full || tbl_alive[i] || now < tbl_time[i] ||
                           ({16'd0, now - tbl_time[i]} < {32'd0, cfg_linger});
                    if (keep) begin
                        if (!full) begin
                            ids.push_back(tbl_id[i]);
                            addrs.push_back(tbl_addr[i]);
                            if (ids.size() == xmrt_pkg::SEARCH_LIMIT) full = 1;
                        end
                        slot_copy(base + w, i);
                        w++;
                    end else begin
                        tbl_peers--;
                    end
                end
                tbl_fill[b] = w;
            end
            if (fwd) begin
                if (b + 1 < tbl_buckets) b++;
                else fwd = 0;
            end else begin
                b--;
            end
        end
        if (ids.size() == 0) push_result(xmrt_pkg::ST_EMPTY, '0, '0, 1'b1);
        for (i = 0; i < ids.size(); i++)
            push_result(xmrt_pkg::ST_FOUND, ids[i], addrs[i], i == ids.size() - 1);
    endfunction

    task automatic send_item(xmrt_pkg::t_in_item it, bit typed, logic [2:0] st);
        int gap, idx;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        burst_left--;
        n_items++;
        idx = results_due.size();
        if (it.req_type == xmrt_pkg::REQ_SEARCH) table_search(it.node_id, it.now_time);
        else if (it.req_type == REQ_UNUSED)
            push_result(xmrt_pkg::ST_IGNORED, '0, '0, 1'b1);
        else push_result(table_update(it.node_id, it.node_addr, it.now_time,
                                      it.req_type == xmrt_pkg::REQ_ALIVE), '0, '0, 1'b1);
        if (typed) results_due[idx].status = st;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [3:0] a, logic [63:0] d);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= a;
        pwdata <= d;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (a == ADDR_OWN_ID) cfg_own_id = d;
        else cfg_linger = d[31:0];
    endtask

    // receiver stall pattern, mode changes every so often
    int stall_mode, stall_cnt;
    always @(negedge i_clk) begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt % 150 == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 99) < 35);
            default: i_out_stall <= ((stall_cnt % 16) < 9);
        endcase
    end

    always @(posedge i_clk) begin
        xmrt_pkg::t_out_item e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (results_due.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected item act=%h", $time, o_out_item);
            end else begin
                e = results_due.pop_front();
                if (e.status == xmrt_pkg::ST_FOUND) n_found++;
                if (o_out_item.status !== e.status || o_out_item.found_id !== e.found_id ||
                    o_out_item.found_addr !== e.found_addr ||
                    o_out_item.peer_count !== e.peer_count || o_out_item.last !== e.last) begin
                    n_errors++;
                    $display("%0t: mismatch exp st=%0d id=%h addr=%h peers=%0d last=%0b",
                             $time, e.status, e.found_id, e.found_addr, e.peer_count, e.last);
                    $display("%0t:          act st=%0d id=%h addr=%h peers=%0d last=%0b",
                             $time, o_out_item.status, o_out_item.found_id,
                             o_out_item.found_addr, o_out_item.peer_count, o_out_item.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    typedef struct {
        logic [1:0]  req;
        logic [63:0] id;
        logic [47:0] addr;
        logic [47:0] now;
        bit          typed;
        logic [2:0]  st;
    } t_row;

    t_row directed[] = '{
        '{xmrt_pkg::REQ_SEARCH,  64'h0, 48'h0, 48'd1000, 1, xmrt_pkg::ST_EMPTY},
        '{xmrt_pkg::REQ_TIMEOUT, 64'h5, 48'h5, 48'd1000, 1, xmrt_pkg::ST_IGNORED},
        '{xmrt_pkg::REQ_ALIVE,   '1, '1, 48'd1000, 1, xmrt_pkg::ST_INSERTED},
        '{xmrt_pkg::REQ_ALIVE,   64'h0, 48'h0, 48'd1000, 1, xmrt_pkg::ST_INSERTED},
        '{xmrt_pkg::REQ_ALIVE,   '1, 48'h1, 48'd1100, 1, xmrt_pkg::ST_REFRESHED},
        '{xmrt_pkg::REQ_TIMEOUT, '1, 48'h2, 48'd1200, 1, xmrt_pkg::ST_IGNORED},
        '{xmrt_pkg::REQ_TIMEOUT, '1, 48'h1, 48'd1300, 1, xmrt_pkg::ST_DEAD},
        '{REQ_UNUSED,            '1, '1, '1, 1, xmrt_pkg::ST_IGNORED},
        '{xmrt_pkg::REQ_SEARCH,  '1, 48'h0, 48'd1400, 0, xmrt_pkg::ST_EMPTY},
        '{xmrt_pkg::REQ_ALIVE,   64'h8000_0000_0000_0000, 48'h5, 48'h0, 1,
          xmrt_pkg::ST_INSERTED},
        '{xmrt_pkg::REQ_ALIVE,   64'h1, 48'h8000_0000_0000, '1, 1, xmrt_pkg::ST_INSERTED},
        '{xmrt_pkg::REQ_SEARCH,  64'h1, 48'h0, 48'h0, 0, xmrt_pkg::ST_EMPTY},
        '{xmrt_pkg::REQ_SEARCH,  64'h0, 48'h0, '1, 0, xmrt_pkg::ST_EMPTY},
        '{xmrt_pkg::REQ_TIMEOUT, 64'h0, 48'h0, '1, 1, xmrt_pkg::ST_DEAD},
        '{xmrt_pkg::REQ_SEARCH,  '1, 48'h0, 48'h7fff_ffff_ffff, 0, xmrt_pkg::ST_EMPTY},
        '{xmrt_pkg::REQ_SEARCH,  64'h0, 48'h0, '1, 0, xmrt_pkg::ST_EMPTY}
    };

    logic [63:0] known_id[$];
    logic [47:0] known_addr[$];
    logic [47:0] clock_us;

    task automatic random_item();
        xmrt_pkg::t_in_item it;
        int pick, j;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0) clock_us += 48'($urandom());
        else clock_us += 48'($urandom_range(0, 3000));
        it.now_time = ($urandom_range(0, 29) == 0) ? 48'({$urandom(), $urandom()}) : clock_us;
        it.node_addr = 48'({$urandom(), $urandom()});
        if (pick < 40 || known_id.size() == 0) begin
            it.req_type = xmrt_pkg::REQ_ALIVE;
            if ($urandom_range(0, 1)) it.node_id = {$urandom(), $urandom()};
            else it.node_id = cfg_own_id ^ ({$urandom(), $urandom()} >> $urandom_range(0, 63));
            known_id.push_back(it.node_id);
            known_addr.push_back(it.node_addr);
        end else if (pick < 55) begin
            j = $urandom_range(0, known_id.size() - 1);
            it.req_type = xmrt_pkg::REQ_ALIVE;
            it.node_id = known_id[j];
            known_addr[j] = it.node_addr;
        end else if (pick < 72) begin
            j = $urandom_range(0, known_id.size() - 1);
            it.req_type = xmrt_pkg::REQ_TIMEOUT;
            it.node_id = known_id[j];
            if ($urandom_range(0, 5) != 0) it.node_addr = known_addr[j];
        end else if (pick < 95) begin
            it.req_type = xmrt_pkg::REQ_SEARCH;
            if ($urandom_range(0, 1)) it.node_id = {$urandom(), $urandom()};
            else it.node_id = cfg_own_id ^ ({$urandom(), $urandom()} >> $urandom_range(0, 63));
        end else begin
            it.req_type = REQ_UNUSED;
            it.node_id = {$urandom(), $urandom()};
        end
        send_item(it, 0, xmrt_pkg::ST_EMPTY);
    endtask

    initial begin
        xmrt_pkg::t_in_item it;
        int p, n;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_out_stall = 1'b0;
        stall_mode = 0;
        stall_cnt = 1;
        cycles = 0;
        n_items = 0;
        n_results = 0;
        n_errors = 0;
        n_found = 0;
        burst_left = 0;
        clock_us = 48'd10000;
        cfg_own_id = '0;
        cfg_linger = xmrt_pkg::LINGER_RESET;
        tbl_buckets = 1;
        tbl_peers = '0;
        foreach (tbl_fill[b]) tbl_fill[b] = 0;
        foreach (tbl_alive[s]) tbl_alive[s] = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[r]) begin
            it.req_type = directed[r].req;
            it.node_id = directed[r].id;
            it.node_addr = directed[r].addr;
            it.now_time = directed[r].now;
            send_item(it, directed[r].typed, directed[r].st);
        end
        drain_results();

        for (p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    apb_write(ADDR_OWN_ID, {$urandom(), $urandom()});
                    apb_write(ADDR_LINGER, 64'd5000);
                end
                1: begin
                    apb_write(ADDR_OWN_ID, '1);
                    apb_write(ADDR_LINGER, 64'd0);
                end
                2: begin
                    apb_write(ADDR_OWN_ID, '0);
                    apb_write(ADDR_LINGER, '1);
                end
                default: begin
                    apb_write(ADDR_OWN_ID, {$urandom(), $urandom()});
                    apb_write(ADDR_LINGER, 64'($urandom_range(0, 100000)));
                end
            endcase
            // close ids cascade the last bucket through several splits
            if (p == 0) begin
                for (n = 0; n < SLOTS; n++) begin
                    it.req_type = xmrt_pkg::REQ_ALIVE;
                    it.node_id = cfg_own_id ^ 64'(n);
                    it.node_addr = 48'({$urandom(), $urandom()});
                    it.now_time = clock_us;
                    send_item(it, 0, xmrt_pkg::ST_EMPTY);
                end
            end
            for (n = 0; n < 25; n++) begin
                random_item();
                if (p == 1 && n == 15) drain_results();
            end
            drain_results();
        end

        $display("run covered %0d request items, %0d result items (%0d found entries)",
                 n_items, n_results, n_found);
        $display("four register settings, %0d buckets and %0d peers at the end",
                 tbl_buckets, tbl_peers);
        if (n_errors == 0 && results_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### xor_metric_routing_table.f
hw/rtl/xmrt_pkg.sv
hw/rtl/xor_metric_routing_table.sv
tb/tb_xor_metric_routing_table.sv
